>>> rtl/spc_pkg.sv
// stack permutation check: shared widths and defaults
// no dependencies

package spc_pkg;

    localparam int unsigned CAR_W        = 11;
    localparam int unsigned CAR_MAX      = (1 << CAR_W) - 1;
    localparam int unsigned DEF_MAX_CARS = 1024;

    localparam logic [CAR_W-1:0] LEN_RESET = CAR_W'(1);

    typedef logic [CAR_W-1:0] car_t;

    // run of consecutive car numbers held on the siding
    typedef struct packed {
        car_t lo;
        car_t hi;
    } run_t;

endpackage

>>> rtl/stack_permutation_check.sv
// stack permutation check top level: siding test for permutations of 1..n
// depends on spc_pkg

// Usage: train_length is written through cfg_wr_en / cfg_wr_data while the
// block is idle; a write also drops any permutation in progress. Cars enter
// one per beat on s_valid / s_ready with s_car_number. After the n-th car of
// a permutation one beat leaves on m_valid / m_ready with m_feasible, and the
// block clears itself for the next permutation.
// Each car is accepted in the idle state, then makes one update of the
// siding in the exec state before the next car is taken. A car that empties
// the top run of the siding while older runs remain also passes a load
// state: the next run comes back from the run memory through a registered
// read. The siding is kept as runs of consecutive cars, the top run in
// registers and the rest in a memory of MAX_CARS entries.
// Reset: train_length returns to 1, the siding is empty, no beat is pending;
// the memory needs no clearing since only written entries are read.
// Stall: the verdict sits in the output register; further cars are still
// accepted, and only a car that would produce the next verdict waits in its
// update cycle until the pending beat is taken.
module stack_permutation_check
    import spc_pkg::*;
#(
    parameter int unsigned MAX_CARS = DEF_MAX_CARS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CAR_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CAR_W-1:0] s_car_number,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_feasible
);

    localparam int unsigned AW     = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int unsigned CAP    = (MAX_CARS > CAR_MAX) ? CAR_MAX : MAX_CARS;
    localparam logic [CAR_W-1:0] CAP_LEN = CAR_W'(CAP);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t         state_reg, state_next;
    car_t           len_reg;
    car_t           car_reg;
    car_t           next_in_reg, next_in_next;
    car_t           pos_reg, pos_next;
    logic           failed_reg, failed_next;
    logic [AW:0]    sp_reg, sp_next;
    run_t           top_reg, top_next;
    logic           top_vld_reg, top_vld_next;
    logic           m_valid_reg, m_valid_next;
    logic           m_feasible_reg, m_feasible_next;

    run_t           mem [MAX_CARS];
    run_t           rdata_reg;
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_waddr;
    logic [AW-1:0]  mem_raddr;

    car_t           n_eff;
    logic           out_busy;
    logic           last_car;
    logic [CAR_W:0] pos_inc;

    assign n_eff    = (len_reg == '0) ? LEN_RESET :
                      ((len_reg > CAP_LEN) ? CAP_LEN : len_reg);
    assign out_busy = m_valid_reg && !m_ready;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign last_car = pos_inc >= {1'b0, n_eff};

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_feasible = m_feasible_reg;

    assign mem_waddr = sp_reg[AW-1:0];
    assign mem_raddr = AW'(sp_reg - 1'b1);

    always_comb begin
        state_next      = state_reg;
        next_in_next    = next_in_reg;
        pos_next        = pos_reg;
        failed_next     = failed_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        top_vld_next    = top_vld_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_feasible_next = m_feasible_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!(last_car && out_busy)) begin
                    state_next = ST_IDLE;
                    if (!failed_reg) begin
                        if (car_reg == '0 || car_reg > n_eff) begin
                            failed_next = 1'b1;
                        end else if (car_reg >= next_in_reg) begin
                            // push the skipped cars as one run, the car itself passes through
                            next_in_next = car_reg + 1'b1;
                            if (car_reg != next_in_reg) begin
                                if (top_vld_reg) begin
                                    mem_we  = 1'b1;
                                    sp_next = sp_reg + 1'b1;
                                end
                                top_next.lo  = next_in_reg;
                                top_next.hi  = car_reg - 1'b1;
                                top_vld_next = 1'b1;
                            end
                        end else if (top_vld_reg && top_reg.hi == car_reg) begin
                            if (top_reg.lo != top_reg.hi) begin
                                top_next.hi = top_reg.hi - 1'b1;
                            end else if (sp_reg != '0) begin
                                mem_re  = 1'b1;
                                sp_next = sp_reg - 1'b1;
                                if (!last_car) begin
                                    state_next = ST_LOAD;
                                end
                            end else begin
                                top_vld_next = 1'b0;
                            end
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    pos_next = pos_inc[CAR_W-1:0];
                    if (last_car) begin
                        m_valid_next    = 1'b1;
                        m_feasible_next = !failed_next;
                        next_in_next    = LEN_RESET;
                        pos_next        = '0;
                        failed_next     = 1'b0;
                        sp_next         = '0;
                        top_vld_next    = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                top_next   = rdata_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            len_reg        <= LEN_RESET;
            next_in_reg    <= LEN_RESET;
            pos_reg        <= '0;
            failed_reg     <= 1'b0;
            sp_reg         <= '0;
            top_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_feasible_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            m_feasible_reg <= m_feasible_next;
            if (cfg_wr_en) begin
                len_reg     <= cfg_wr_data;
                state_reg   <= ST_IDLE;
                next_in_reg <= LEN_RESET;
                pos_reg     <= '0;
                failed_reg  <= 1'b0;
                sp_reg      <= '0;
                top_vld_reg <= 1'b0;
            end else begin
                state_reg   <= state_next;
                next_in_reg <= next_in_next;
                pos_reg     <= pos_next;
                failed_reg  <= failed_next;
                sp_reg      <= sp_next;
                top_vld_reg <= top_vld_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (s_valid && s_ready) begin
            car_reg <= s_car_number;
        end
    end

    // run memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= top_reg;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule
